// ===== rtl/core/pma_pkg.sv =====
// ----------------------------------------------------------------------------
// Prototype mask assembler package
// Shared widths, register indexes, stage types and the sigmoid lookup table.
// ----------------------------------------------------------------------------
package pma_pkg;

   localparam int MAX_PROTOTYPES = 32;
   localparam int VALUE_WIDTH    = 16;
   localparam int CH_WIDTH       = 5;
   localparam int CNT_WIDTH      = 6;
   localparam int ADDR_WIDTH     = $clog2(MAX_PROTOTYPES);
   localparam int PROD_WIDTH     = 2 * VALUE_WIDTH;
   localparam int ACC_WIDTH      = 40;
   localparam int ALPHA_WIDTH    = 16;
   localparam int FLOOR_WIDTH    = 16;
   localparam int GAIN_WIDTH     = 24;
   localparam int SCALED_WIDTH   = ALPHA_WIDTH + GAIN_WIDTH;
   localparam int GAIN_FRAC      = 16;

   localparam int TABLE_SIZE     = 1024;
   localparam int HALF_TABLE     = TABLE_SIZE / 2;
   localparam int IDX_WIDTH      = $clog2(TABLE_SIZE);
   // The sum is biased by 8.0 in Q16.24; the table index is its top bits.
   localparam int BIAS_WIDTH     = 28;
   localparam int SUM_SHIFT      = BIAS_WIDTH - IDX_WIDTH;
   localparam logic signed [ACC_WIDTH:0] SUM_SPAN = (ACC_WIDTH + 1)'(1) << (BIAS_WIDTH - 1);

   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 24;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_NUM_PROTOTYPES = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_NOISE_FLOOR    = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_NOISE_GAIN     = 2'd2;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PROTO = 1'b1;

   localparam int REQ_DATA_WIDTH = 24;
   localparam int RSP_DATA_WIDTH = 16;

   typedef logic [ALPHA_WIDTH-1:0] sig_table_type [TABLE_SIZE];

   // Finished pixel sum handed from the accumulator to the activation pipe.
   typedef struct packed {
      logic                        valid;
      logic                        last;
      logic signed [ACC_WIDTH-1:0] sum;
   } pma_sum_type;

   // Unsigned restoring long division, used only while the table is built.
   function automatic logic [63:0] div_u64(input logic [63:0] num,
                                           input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Sigmoid at bin centers in Q0.16, built with exact integer steps:
   // exp(-1/128) by its series, then repeated products by exp(-1/64).
   function automatic sig_table_type build_sig_table();
      logic [63:0]   one;
      logic [63:0]   term;
      logic [63:0]   f;
      logic [63:0]   g;
      logic [63:0]   e;
      logic [63:0]   den;
      logic [63:0]   hi;
      logic [63:0]   lo;
      logic [127:0]  wide;
      sig_table_type tbl;
      one  = 64'd1 << 32;
      term = one;
      f    = one;
      for (int n = 1; n < 10; n++) begin
         term = div_u64(term, 64'd128 * 64'(n));
         if (n[0] == 1'b1) begin
            f = f - term;
         end else begin
            f = f + term;
         end
      end
      wide = 128'(f) * 128'(f);
      g    = wide[95:32];
      e    = f;
      for (int k = 0; k < HALF_TABLE; k++) begin
         den = one + e;
         hi  = div_u64((64'd1 << 48) + (den >> 1), den);
         if (hi > 64'd65535) begin
            hi = 64'd65535;
         end
         lo  = div_u64((e << 16) + (den >> 1), den);
         tbl[HALF_TABLE + k]     = hi[ALPHA_WIDTH-1:0];
         tbl[HALF_TABLE - 1 - k] = lo[ALPHA_WIDTH-1:0];
         wide = 128'(e) * 128'(g);
         e    = wide[95:32];
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

// ===== rtl/core/pma_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/pma_mac.sv =====
// ----------------------------------------------------------------------------
// Prototype mask assembler multiply-accumulate
// Stores coefficients, reads one per prototype beat, multiplies and sums
// the channels of a pixel, and hands the finished sum downstream.
// ----------------------------------------------------------------------------
module pma_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic                                   req_kind,
   input  logic [pma_pkg::CH_WIDTH-1:0]           req_channel,
   input  logic signed [pma_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                                   req_last,
   input  logic [pma_pkg::CNT_WIDTH-1:0]          channel_count,
   output pma_pkg::pma_sum_type                   sum_out,
   input  logic                                   sum_ready
);

   logic                                   accept;
   logic                                   is_proto;
   logic                                   is_end;
   logic                                   ram_we;
   logic [pma_pkg::CNT_WIDTH-1:0]          channel_ext;
   logic signed [pma_pkg::VALUE_WIDTH-1:0] coef1;
   logic [pma_pkg::VALUE_WIDTH-1:0]        coef_raw;

   logic                                   ready1;
   logic                                   ready2;
   logic                                   ready3;

   logic                                   v1_ff;
   logic                                   end1_ff;
   logic                                   last1_ff;
   logic signed [pma_pkg::VALUE_WIDTH-1:0] val1_ff;

   logic                                   v2_ff;
   logic                                   end2_ff;
   logic                                   last2_ff;
   logic signed [pma_pkg::PROD_WIDTH-1:0]  prod2_ff;

   logic signed [pma_pkg::ACC_WIDTH-1:0]   acc_ff;
   logic signed [pma_pkg::ACC_WIDTH-1:0]   acc_in;
   logic signed [pma_pkg::ACC_WIDTH-1:0]   acc_sum;
   logic                                   consume;

   logic                                   sum_valid_ff;
   logic                                   sum_last_ff;
   logic signed [pma_pkg::ACC_WIDTH-1:0]   sum_ff;

   assign ready3 = !sum_valid_ff || sum_ready;
   assign ready2 = !v2_ff || !end2_ff || ready3;
   assign ready1 = !v1_ff || ready2;

   assign req_tready = ready1;
   assign accept     = req_tvalid && ready1;

   assign channel_ext = pma_pkg::CNT_WIDTH'(req_channel);
   assign is_proto    = (req_kind == pma_pkg::KIND_PROTO) && (channel_ext < channel_count);
   assign is_end      = channel_ext == (channel_count - pma_pkg::CNT_WIDTH'(1));
   assign ram_we      = accept && (req_kind == pma_pkg::KIND_LOAD) &&
                        (32'(req_channel) < pma_pkg::MAX_PROTOTYPES);

   pma_ram #(
      .WIDTH (pma_pkg::VALUE_WIDTH),
      .DEPTH (pma_pkg::MAX_PROTOTYPES)
   ) u_coef_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_channel[pma_pkg::ADDR_WIDTH-1:0]),
      .wdata (req_value),
      .re    (ready1),
      .raddr (req_channel[pma_pkg::ADDR_WIDTH-1:0]),
      .rdata (coef_raw)
   );

   assign coef1 = coef_raw;

   // A beat leaves the product stage into the accumulator; the pixel's last
   // channel also needs room in the sum register.
   assign consume = v2_ff && (!end2_ff || ready3);
   assign acc_sum = acc_ff + pma_pkg::ACC_WIDTH'(prod2_ff);

   always_comb begin
      acc_in = acc_ff;
      if (consume) begin
         if (end2_ff) begin
            acc_in = '0;
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         sum_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         acc_ff <= acc_in;
         if (ready1) begin
            v1_ff <= accept && is_proto;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            sum_valid_ff <= v2_ff && end2_ff;
         end
      end
      if (ready1) begin
         val1_ff  <= req_value;
         end1_ff  <= is_end;
         last1_ff <= req_last;
      end
      if (ready2) begin
         prod2_ff <= coef1 * val1_ff;
         end2_ff  <= end1_ff;
         last2_ff <= last1_ff;
      end
      if (ready3) begin
         sum_ff      <= acc_sum;
         sum_last_ff <= last2_ff;
      end
   end

   assign sum_out.valid = sum_valid_ff;
   assign sum_out.last  = sum_last_ff;
   assign sum_out.sum   = sum_ff;

endmodule

// ===== rtl/core/pma_activate.sv =====
// ----------------------------------------------------------------------------
// Prototype mask assembler activation
// Saturates the pixel sum, looks up the sigmoid, applies the noise floor
// and gain, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module pma_activate (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pma_pkg::pma_sum_type                 sum_in,
   output logic                                 sum_ready,
   input  logic [pma_pkg::FLOOR_WIDTH-1:0]      noise_floor,
   input  logic [pma_pkg::GAIN_WIDTH-1:0]       noise_gain,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pma_pkg::ALPHA_WIDTH-1:0]      rsp_alpha,
   output logic                                 rsp_last
);

   logic                                   ready_a;
   logic                                   ready_b;
   logic                                   ready_c;
   logic                                   ready_d;
   logic                                   ready_e;

   logic signed [pma_pkg::ACC_WIDTH:0]     biased;
   logic [pma_pkg::IDX_WIDTH-1:0]          idx;
   logic [pma_pkg::GAIN_WIDTH-1:0]         scaled;
   logic [pma_pkg::ALPHA_WIDTH-1:0]        result;

   logic                                   va_ff;
   logic                                   lasta_ff;
   logic [pma_pkg::IDX_WIDTH-1:0]          idxa_ff;

   logic                                   vb_ff;
   logic                                   lastb_ff;
   logic [pma_pkg::ALPHA_WIDTH-1:0]        alphab_ff;

   logic                                   vc_ff;
   logic                                   lastc_ff;
   logic                                   bypassc_ff;
   logic                                   passc_ff;
   logic [pma_pkg::ALPHA_WIDTH-1:0]        alphac_ff;
   logic [pma_pkg::ALPHA_WIDTH-1:0]        diffc_ff;

   logic                                   vd_ff;
   logic                                   lastd_ff;
   logic                                   bypassd_ff;
   logic                                   passd_ff;
   logic [pma_pkg::ALPHA_WIDTH-1:0]        alphad_ff;
   logic [pma_pkg::SCALED_WIDTH-1:0]       prodd_ff;

   logic                                   ve_ff;
   logic                                   laste_ff;
   logic [pma_pkg::ALPHA_WIDTH-1:0]        alphae_ff;

   assign ready_e   = !ve_ff || rsp_tready;
   assign ready_d   = !vd_ff || ready_e;
   assign ready_c   = !vc_ff || ready_d;
   assign ready_b   = !vb_ff || ready_c;
   assign ready_a   = !va_ff || ready_b;
   assign sum_ready = ready_a;

   // Biasing by 8.0 maps the saturation window onto [0, 2^28).
   assign biased = (pma_pkg::ACC_WIDTH + 1)'(sum_in.sum) + pma_pkg::SUM_SPAN;

   always_comb begin
      if (biased[pma_pkg::ACC_WIDTH]) begin
         idx = '0;
      end else if (biased[pma_pkg::ACC_WIDTH-1:pma_pkg::BIAS_WIDTH] != '0) begin
         idx = '1;
      end else begin
         idx = biased[pma_pkg::BIAS_WIDTH-1:pma_pkg::SUM_SHIFT];
      end
   end

   assign scaled = prodd_ff[pma_pkg::SCALED_WIDTH-1:pma_pkg::GAIN_FRAC];

   always_comb begin
      if (bypassd_ff) begin
         result = alphad_ff;
      end else if (!passd_ff) begin
         result = '0;
      end else if (scaled[pma_pkg::GAIN_WIDTH-1:pma_pkg::ALPHA_WIDTH] != '0) begin
         result = '1;
      end else begin
         result = scaled[pma_pkg::ALPHA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            va_ff <= sum_in.valid;
         end
         if (ready_b) begin
            vb_ff <= va_ff;
         end
         if (ready_c) begin
            vc_ff <= vb_ff;
         end
         if (ready_d) begin
            vd_ff <= vc_ff;
         end
         if (ready_e) begin
            ve_ff <= vd_ff;
         end
      end
      if (ready_a) begin
         idxa_ff  <= idx;
         lasta_ff <= sum_in.last;
      end
      if (ready_b) begin
         alphab_ff <= pma_pkg::SIG_TABLE[idxa_ff];
         lastb_ff  <= lasta_ff;
      end
      if (ready_c) begin
         bypassc_ff <= noise_floor == '0;
         passc_ff   <= alphab_ff > noise_floor;
         diffc_ff   <= alphab_ff - noise_floor;
         alphac_ff  <= alphab_ff;
         lastc_ff   <= lastb_ff;
      end
      if (ready_d) begin
         prodd_ff   <= pma_pkg::SCALED_WIDTH'(diffc_ff) * pma_pkg::SCALED_WIDTH'(noise_gain);
         bypassd_ff <= bypassc_ff;
         passd_ff   <= passc_ff;
         alphad_ff  <= alphac_ff;
         lastd_ff   <= lastc_ff;
      end
      if (ready_e) begin
         alphae_ff <= result;
         laste_ff  <= lastd_ff;
      end
   end

   assign rsp_tvalid = ve_ff;
   assign rsp_alpha  = alphae_ff;
   assign rsp_last   = laste_ff;

endmodule

// ===== rtl/core/prototype_mask_assembler.sv =====
// ----------------------------------------------------------------------------
// Prototype mask assembler
// Assembles one instance mask pixel by pixel from prototype channels and
// stored per-prototype coefficients, through a sigmoid and a noise floor.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle while the result stream does not stall; one
// result beat per pixel, that is per num_prototypes prototype beats.
// Path of a pixel's last channel beat, through registered stages in order:
// coefficient RAM read, multiply, accumulate, index, table, floor, gain, output.
// Reset clears the pipeline, the accumulator and the registers to their
// defaults; the coefficient store is not cleared and must be loaded first.
module prototype_mask_assembler (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [pma_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,  // channel[4:0], value[20:5]
   input  logic                                   req_tuser,  // kind
   input  logic                                   req_tlast,  // last_pixel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [pma_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,  // alpha[15:0]
   output logic                                   rsp_tlast,  // last_of_mask
   input  logic                                   csr_we,
   input  logic [pma_pkg::CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  logic [pma_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   logic [pma_pkg::CNT_WIDTH-1:0]   num_prototypes_ff;
   logic [pma_pkg::CNT_WIDTH-1:0]   num_prototypes_in;
   logic [pma_pkg::FLOOR_WIDTH-1:0] noise_floor_ff;
   logic [pma_pkg::FLOOR_WIDTH-1:0] noise_floor_in;
   logic [pma_pkg::GAIN_WIDTH-1:0]  noise_gain_ff;
   logic [pma_pkg::GAIN_WIDTH-1:0]  noise_gain_in;
   logic [pma_pkg::CNT_WIDTH-1:0]   channel_count;
   pma_pkg::pma_sum_type            sum_stage;
   logic                            sum_ready;

   always_comb begin
      num_prototypes_in = num_prototypes_ff;
      noise_floor_in    = noise_floor_ff;
      noise_gain_in     = noise_gain_ff;
      if (csr_we) begin
         unique case (csr_addr)
            pma_pkg::CSR_NUM_PROTOTYPES: num_prototypes_in = csr_wdata[pma_pkg::CNT_WIDTH-1:0];
            pma_pkg::CSR_NOISE_FLOOR:    noise_floor_in    = csr_wdata[pma_pkg::FLOOR_WIDTH-1:0];
            pma_pkg::CSR_NOISE_GAIN:     noise_gain_in     = csr_wdata[pma_pkg::GAIN_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_prototypes_ff <= pma_pkg::CNT_WIDTH'(pma_pkg::MAX_PROTOTYPES);
         noise_floor_ff    <= '0;
         noise_gain_ff     <= pma_pkg::GAIN_WIDTH'(1 << pma_pkg::GAIN_FRAC);
      end else begin
         num_prototypes_ff <= num_prototypes_in;
         noise_floor_ff    <= noise_floor_in;
         noise_gain_ff     <= noise_gain_in;
      end
   end

   // A count of zero acts as one channel; counts above the store depth clip.
   always_comb begin
      if (num_prototypes_ff == '0) begin
         channel_count = pma_pkg::CNT_WIDTH'(1);
      end else if (32'(num_prototypes_ff) > pma_pkg::MAX_PROTOTYPES) begin
         channel_count = pma_pkg::CNT_WIDTH'(pma_pkg::MAX_PROTOTYPES);
      end else begin
         channel_count = num_prototypes_ff;
      end
   end

   pma_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_kind      (req_tuser),
      .req_channel   (req_tdata[pma_pkg::CH_WIDTH-1:0]),
      .req_value     (req_tdata[pma_pkg::CH_WIDTH +: pma_pkg::VALUE_WIDTH]),
      .req_last      (req_tlast),
      .channel_count (channel_count),
      .sum_out       (sum_stage),
      .sum_ready     (sum_ready)
   );

   pma_activate u_activate (
      .clock       (clock),
      .reset       (reset),
      .sum_in      (sum_stage),
      .sum_ready   (sum_ready),
      .noise_floor (noise_floor_ff),
      .noise_gain  (noise_gain_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_alpha   (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

endmodule

// ===== test/prototype_mask_assembler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prototype mask assembler testbench
// Streams coefficient loads and prototype channel values into the assembler
// and checks every finished pixel against a cycle-free predictor. The predictor
// covers the store, the 40-bit accumulator, the sigmoid lookup and the noise
// floor. Runs through several register settings and random idle and stall
// patterns on both streams.
// ----------------------------------------------------------------------------
module prototype_mask_assembler_tb;

   localparam int PERIOD_HALF  = 2;
   localparam int SETTLE_BEATS = 16;
   localparam int CYCLE_LIMIT  = 300000;
   localparam logic [pma_pkg::CSR_ADDR_WIDTH-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic                                   kind;
      logic [pma_pkg::CH_WIDTH-1:0]           channel;
      logic signed [pma_pkg::VALUE_WIDTH-1:0] value;
      logic                                   last;
      logic                                   hold;
   } proto_beat_type;

   typedef struct {
      logic [pma_pkg::ALPHA_WIDTH-1:0] alpha;
      logic                            last;
   } mask_pixel_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [pma_pkg::REQ_DATA_WIDTH-1:0] req_tdata  = '0;  // channel[4:0], value[20:5]
   logic                               req_tuser  = 1'b0;  // kind
   logic                               req_tlast  = 1'b0;  // last_pixel
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [pma_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;  // alpha[15:0]
   logic                               rsp_tlast;  // last_of_mask
   logic                               csr_we     = 1'b0;
   logic [pma_pkg::CSR_ADDR_WIDTH-1:0] csr_addr   = '0;
   logic [pma_pkg::CSR_DATA_WIDTH-1:0] csr_wdata  = '0;

   // Predictor state and register copies.
   logic [pma_pkg::ALPHA_WIDTH-1:0]        sigmoid_lut [pma_pkg::TABLE_SIZE];
   logic signed [pma_pkg::VALUE_WIDTH-1:0] coef_store [pma_pkg::MAX_PROTOTYPES];
   logic [pma_pkg::ACC_WIDTH-1:0]          pixel_acc = '0;
   logic [pma_pkg::CNT_WIDTH-1:0]          cfg_count = 6'd32;
   logic [pma_pkg::FLOOR_WIDTH-1:0]        cfg_floor = '0;
   logic [pma_pkg::GAIN_WIDTH-1:0]         cfg_gain  = 24'd65536;

   proto_beat_type beat_q [$];
   mask_pixel_type pixel_q [$];
   proto_beat_type cur_beat;
   int             beats_pushed   = 0;
   int             beats_accepted = 0;
   int             error_count    = 0;
   int             cycle_count    = 0;
   int             sender_idle_pct = 0;
   int             rsp_stall_pct   = 0;

   prototype_mask_assembler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #(PERIOD_HALF) clock = ~clock;
   end

   // Sigmoid at bin centers: exp(-1/128) from its series in Q0.32, then
   // truncating steps by exp(-1/64), each entry a rounded divide.
   function automatic void fill_sigmoid_lut();
      logic [63:0] unit;
      logic [63:0] term;
      logic [63:0] e_half;
      logic [63:0] e_step;
      logic [63:0] e_cur;
      logic [63:0] den;
      logic [63:0] upper;
      logic [63:0] lower;
      unit   = 64'd1 << 32;
      term   = unit;
      e_half = unit;
      for (int n = 1; n < 10; n++) begin
         term = term / (64'd128 * 64'(n));
         if (n % 2 == 1) begin
            e_half = e_half - term;
         end else begin
            e_half = e_half + term;
         end
      end
      e_step = (e_half * e_half) >> 32;
      e_cur  = e_half;
      for (int k = 0; k < pma_pkg::TABLE_SIZE / 2; k++) begin
         den   = unit + e_cur;
         upper = ((64'd1 << 48) + den / 64'd2) / den;
         if (upper > 64'd65535) begin
            upper = 64'd65535;
         end
         lower = ((e_cur << 16) + den / 64'd2) / den;
         sigmoid_lut[pma_pkg::TABLE_SIZE / 2 + k]     = upper[15:0];
         sigmoid_lut[pma_pkg::TABLE_SIZE / 2 - 1 - k] = lower[15:0];
         e_cur = (e_cur * e_step) >> 32;
      end
   endfunction

   function automatic int eff_count(input logic [pma_pkg::CNT_WIDTH-1:0] c);
      if (c < 1) return 1;
      if (c > pma_pkg::MAX_PROTOTYPES) return pma_pkg::MAX_PROTOTYPES;
      return int'(c);
   endfunction

   // Applies one accepted beat to the predictor and queues the finished pixel.
   function automatic void accumulate_beat(input proto_beat_type b);
      int                                    n;
      logic signed [pma_pkg::ACC_WIDTH-1:0]  prod;
      logic signed [pma_pkg::ACC_WIDTH-1:0]  sum;
      logic [pma_pkg::ACC_WIDTH-1:0]         biased;
      logic [pma_pkg::ACC_WIDTH-1:0]         scaled;
      logic [pma_pkg::ALPHA_WIDTH-1:0]       alpha;
      mask_pixel_type                        px;
      n = eff_count(cfg_count);
      if (b.kind == pma_pkg::KIND_LOAD) begin
         coef_store[b.channel] = b.value;
         return;
      end
      if (int'(b.channel) >= n) return;
      prod      = coef_store[b.channel] * b.value;
      pixel_acc = pixel_acc + prod;
      if (int'(b.channel) != n - 1) return;
      sum       = pixel_acc;
      pixel_acc = '0;
      if (sum < -40'sd134217728) sum = -40'sd134217728;
      if (sum > 40'sd134217727) sum = 40'sd134217727;
      biased = sum + 40'sd134217728;
      alpha  = sigmoid_lut[biased[27:18]];
      if (cfg_floor != '0) begin
         if (alpha <= cfg_floor) begin
            alpha = '0;
         end else begin
            scaled = (40'(alpha) - 40'(cfg_floor)) * 40'(cfg_gain);
            scaled = scaled >> pma_pkg::GAIN_FRAC;
            alpha  = (scaled > 40'd65535) ? 16'hFFFF : scaled[15:0];
         end
      end
      px.alpha = alpha;
      px.last  = b.last;
      pixel_q.insert(pixel_q.size(), px);
   endfunction

   function automatic void push_beat(input logic kind, input int channel,
                                     input logic signed [pma_pkg::VALUE_WIDTH-1:0] value,
                                     input logic last, input logic hold = 1'b0);
      proto_beat_type b;
      b.kind    = kind;
      b.channel = pma_pkg::CH_WIDTH'(channel);
      b.value   = value;
      b.last    = last;
      b.hold    = hold;
      beat_q.insert(beat_q.size(), b);
      beats_pushed++;
   endfunction

   function automatic logic signed [pma_pkg::VALUE_WIDTH-1:0] rand_value(input int shift);
      logic signed [pma_pkg::VALUE_WIDTH-1:0] v;
      v = pma_pkg::VALUE_WIDTH'($urandom);
      return v >>> shift;
   endfunction

   task automatic write_reg(input logic [pma_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            input logic [pma_pkg::CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         pma_pkg::CSR_NUM_PROTOTYPES: cfg_count = data[pma_pkg::CNT_WIDTH-1:0];
         pma_pkg::CSR_NOISE_FLOOR:    cfg_floor = data[pma_pkg::FLOOR_WIDTH-1:0];
         pma_pkg::CSR_NOISE_GAIN:     cfg_gain  = data[pma_pkg::GAIN_WIDTH-1:0];
         default: ;
      endcase
   endtask

   // Waits until every beat is taken and every pixel has come out, then lets
   // trailing accumulate-only beats clear the pipeline.
   task automatic wait_drain();
      while (!(beats_accepted == beats_pushed && pixel_q.size() == 0)) begin
         @(posedge clock);
      end
      repeat (SETTLE_BEATS) @(posedge clock);
   endtask

   task automatic run_phase(input logic [pma_pkg::CNT_WIDTH-1:0] count,
                            input logic [pma_pkg::FLOOR_WIDTH-1:0] floor_val,
                            input logic [pma_pkg::GAIN_WIDTH-1:0] gain_val,
                            input int idle_pct, input int stall_pct,
                            input bit wrap_run);
      int   n;
      int   pushed;
      int   pix_left;
      int   shift;
      int   hold_at;
      bit   hold_done;
      logic mask_end;
      wait_drain();
      write_reg(pma_pkg::CSR_NUM_PROTOTYPES, {18'($urandom), count});
      write_reg(pma_pkg::CSR_NOISE_FLOOR, {8'($urandom), floor_val});
      write_reg(pma_pkg::CSR_NOISE_GAIN, gain_val);
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      n         = eff_count(cfg_count);
      pushed    = 0;
      hold_at   = 85;
      hold_done = 0;
      pix_left  = $urandom_range(6, 1);
      // Fresh coefficients for this instance.
      for (int c = 0; c < pma_pkg::MAX_PROTOTYPES; c++) begin
         push_beat(pma_pkg::KIND_LOAD, c, rand_value($urandom_range(4, 0)),
                   1'($urandom_range(1, 0)));
         pushed++;
      end
      // Long run on one channel so the accumulator wraps past 2^39.
      if (wrap_run) begin
         push_beat(pma_pkg::KIND_LOAD, 0, 16'sh8000, 1'b0);
         repeat (513) push_beat(pma_pkg::KIND_PROTO, 0, 16'sh8000, 1'b0);
         for (int c = 1; c < n; c++) begin
            push_beat(pma_pkg::KIND_PROTO, c, '0, 1'b1);
         end
         pushed += 514 + n - 1;
      end
      while (pushed < 100) begin
         if ($urandom_range(99, 0) < 8) begin
            repeat ($urandom_range(3, 1)) begin
               push_beat(1'($urandom_range(1, 0)), $urandom_range(31, 0),
                         rand_value($urandom_range(6, 0)), 1'($urandom_range(1, 0)));
               pushed++;
            end
         end else begin
            pix_left--;
            mask_end = (pix_left == 0);
            if (mask_end) pix_left = $urandom_range(6, 1);
            shift = $urandom_range(7, 0);
            for (int c = 0; c < n; c++) begin
               if ($urandom_range(99, 0) < 4) begin
                  push_beat(pma_pkg::KIND_LOAD, $urandom_range(31, 0),
                            rand_value($urandom_range(4, 0)), mask_end);
                  pushed++;
               end
               if (n < pma_pkg::MAX_PROTOTYPES && $urandom_range(99, 0) < 4) begin
                  push_beat(pma_pkg::KIND_PROTO, $urandom_range(31, n), rand_value(0),
                            mask_end);
               end
               push_beat(pma_pkg::KIND_PROTO, c, rand_value(shift), mask_end,
                         c == 0 && !hold_done && pushed >= hold_at);
               if (c == 0 && pushed >= hold_at) hold_done = 1;
               pushed++;
            end
         end
      end
   endtask

   // Driver: presents queued beats, predicting each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accumulate_beat(cur_beat);
            beats_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (beat_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct &&
                !(beat_q[0].hold && pixel_q.size() != 0)) begin
               cur_beat = beat_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(pma_pkg::REQ_DATA_WIDTH - pma_pkg::CH_WIDTH -
                                pma_pkg::VALUE_WIDTH){1'b0}},
                              cur_beat.value, cur_beat.channel};
               req_tuser  <= cur_beat.kind;
               req_tlast  <= cur_beat.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result beat against the oldest expected pixel.
   always @(posedge clock) begin
      mask_pixel_type px;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_q.size() == 0) begin
               $error("unexpected result beat: alpha %0d, last_of_mask %0d",
                      rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               px = pixel_q.pop_front();
               if (rsp_tdata != px.alpha) begin
                  $error("alpha mismatch: expected %0d, actual %0d", px.alpha, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast != px.last) begin
                  $error("last_of_mask mismatch: expected %0d, actual %0d",
                         px.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      fill_sigmoid_lut();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: two channels, extremes of value and channel, ignored beats.
      write_reg(pma_pkg::CSR_NUM_PROTOTYPES, 24'd2);
      write_reg(CSR_SPARE, 24'($urandom));
      push_beat(pma_pkg::KIND_LOAD, 0, 16'sh8000, 1'b0);
      push_beat(pma_pkg::KIND_LOAD, 1, 16'sh7FFF, 1'b0);
      push_beat(pma_pkg::KIND_PROTO, 0, 16'sh8000, 1'b0);  // saturates high
      push_beat(pma_pkg::KIND_PROTO, 1, 16'sh0000, 1'b0);
      push_beat(pma_pkg::KIND_PROTO, 0, 16'sh7FFF, 1'b0);  // just below zero
      push_beat(pma_pkg::KIND_PROTO, 1, 16'sh7FFF, 1'b0);
      push_beat(pma_pkg::KIND_PROTO, 0, 16'sh0000, 1'b0);  // saturates low
      push_beat(pma_pkg::KIND_PROTO, 1, 16'sh8000, 1'b0);
      push_beat(pma_pkg::KIND_PROTO, 31, 16'sh7FFF, 1'b1);  // channel past the count
      push_beat(pma_pkg::KIND_PROTO, 5, 16'sh8000, 1'b0);
      push_beat(pma_pkg::KIND_PROTO, 0, 16'sh0000, 1'b0);
      push_beat(pma_pkg::KIND_LOAD, 1, 16'sh0001, 1'b0);    // reload inside a pixel
      push_beat(pma_pkg::KIND_PROTO, 1, 16'sh0800, 1'b0);
      push_beat(pma_pkg::KIND_PROTO, 0, 16'sh0000, 1'b1);   // zero sum, end of mask
      push_beat(pma_pkg::KIND_PROTO, 1, 16'sh0000, 1'b1);
      push_beat(pma_pkg::KIND_LOAD, 31, 16'shFFFF, 1'b1);
      push_beat(pma_pkg::KIND_LOAD, 30, 16'sh5555, 1'b0);

      run_phase(6'd0, 16'h0000, 24'd65536, 0, 0, 0);
      run_phase(6'd63, 16'hFFFF, 24'hFFFFFF, 63, 0, 0);
      run_phase(6'd3, 16'h0001, 24'hFFFFFF, 0, 63, 0);
      run_phase(6'd33, 16'h0000, 24'($urandom), 37, 37, 1);
      run_phase(6'd8, 16'h4000, 24'd87381, 0, 0, 0);
      run_phase(6'd1, 16'h8000, 24'd0, 63, 0, 0);
      run_phase(6'($urandom_range(32, 1)), 16'($urandom), 24'($urandom), 0, 63, 0);
      run_phase(6'd32, 16'hC000, 24'd262144, 37, 37, 0);
      run_phase(6'd5, 16'h0000, 24'($urandom), 0, 0, 0);
      wait_drain();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pma_pkg.sv
rtl/core/pma_ram.sv
rtl/core/pma_mac.sv
rtl/core/pma_activate.sv
rtl/core/prototype_mask_assembler.sv
test/prototype_mask_assembler_tb.sv
